@@ rtl/core/untp_pkg.sv @@
// ----------------------------------------------------------------------------
// Unsigned number text parser package
// Shared types, character codes and the digit decoder of the parser.
// ----------------------------------------------------------------------------
package untp_pkg;

   localparam int OffsetBits = 16;
   localparam int BaseBits   = 5;
   localparam int ValueBits  = 64;
   localparam int EndBits    = 16;
   localparam int AddrBits   = 3;

   localparam logic [7:0] CharZero = 8'h30;
   localparam logic [7:0] CharLowX = 8'h78;
   localparam logic [7:0] CaseBit  = 8'h20;

   localparam logic [BaseBits-1:0] Radix8  = 5'd8;
   localparam logic [BaseBits-1:0] Radix10 = 5'd10;
   localparam logic [BaseBits-1:0] Radix16 = 5'd16;
   localparam logic [BaseBits-1:0] RadixDetect = 5'd0;

   localparam logic [AddrBits-1:0] RegNumberBase = 3'd0;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_ZERO,
      PH_ZERO_X,
      PH_HEX0,
      PH_DIGITS
   } phase_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] val;
   } digit_type;

   function automatic digit_type digit_of(input logic [7:0] c);
      digit_type d;
      d.valid = 1'b1;
      d.val   = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         d.val = 4'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         d.val = 4'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         d.val = 4'(c - 8'h37);
      end else begin
         d.valid = 1'b0;
      end
      return d;
   endfunction

   function automatic logic is_x(input logic [7:0] c);
      return (c | CaseBit) == CharLowX;
   endfunction

endpackage

@@ rtl/core/unsigned_number_text_parser.sv @@
// ----------------------------------------------------------------------------
// Unsigned number text parser
// Parses an unsigned number from a character stream, with base detection.
// ----------------------------------------------------------------------------
// Usage: characters enter one per beat on the req_ channel, ch in tdata and
// the start-of-string flag in tuser. Each string gives at most one beat on the
// rsp_ channel, carrying the value (modulo 2^64) and the end offset, sent on
// the first character that is not a digit of the string's radix. Later
// characters of that string are dropped until the next start flag.
// The radix comes from register 0 (number_base) of the csr_ port and is taken
// at each start character; 0 selects decimal, octal or hex from the prefix.
// An accepted character passes through the input register, then through the
// digit multiply-add into the result register. While the rsp_ channel does
// not stall, one character is taken every cycle; the rate is set by the
// accumulator loop (64 by 5 bit multiply and add).
// A stalled rsp_ channel holds the result register; an empty input register
// still takes one more character, after which req_tready drops until space frees.
// Reset clears the register, the parse state and both valid flags; no beat
// leaves the block after reset until a new string is started.
// ----------------------------------------------------------------------------
module unsigned_number_text_parser (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // [7:0] ch
   input  logic                           req_tuser,   // [0] first
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [79:0]                    rsp_tdata,   // [63:0] value, [79:64] end_offset
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [untp_pkg::AddrBits-1:0]  csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);
   import untp_pkg::*;

   // Configuration
   logic [BaseBits-1:0] number_base_ff;

   // Input register
   logic       in_valid_ff;
   logic [7:0] in_ch_ff;
   logic       in_first_ff;

   // Parse state
   phase_type             phase_ff, phase_in;
   logic [ValueBits-1:0]  acc_ff, acc_in;
   logic [BaseBits-1:0]   base_ff, base_in;
   logic [OffsetBits-1:0] cons_ff, cons_in;

   // Result register
   logic                  out_valid_ff;
   logic [ValueBits-1:0]  out_value_ff, out_value_in;
   logic [EndBits-1:0]    out_end_ff, out_end_in;

   logic                          advance;
   logic                          emit;
   digit_type                     dig;
   logic [ValueBits-1:0]          acc_sel;
   logic [OffsetBits-1:0]         cnt_sel;
   logic [OffsetBits-1:0]         cnt_inc;
   logic [BaseBits-1:0]           base_sel;
   logic [ValueBits+BaseBits-1:0] prod;
   logic [ValueBits-1:0]          acc_step;
   logic                          digit_ok;
   logic [31:0]                   cnt_wide;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == RegNumberBase[2]) ? 32'(number_base_ff) : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         number_base_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite
                   && csr_paddr[2] == RegNumberBase[2]) begin
         number_base_ff <= csr_pwdata[BaseBits-1:0];
      end
   end

   // The parse stage moves only when the result register can take a beat.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_ch_ff    <= req_tdata;
         in_first_ff <= req_tuser;
      end
   end

   assign dig     = digit_of(in_ch_ff);
   assign acc_sel = in_first_ff ? '0 : acc_ff;
   assign cnt_sel = in_first_ff ? '0 : cons_ff;
   assign cnt_inc = (cnt_sel == '1) ? cnt_sel : cnt_sel + 1'b1;

   always_comb begin
      base_sel = base_ff;
      if (in_first_ff) begin
         base_sel = (number_base_ff == RadixDetect) ? Radix10 : number_base_ff;
      end else begin
         case (phase_ff)
            PH_ZERO:   base_sel = Radix8;
            PH_ZERO_X: base_sel = Radix16;
            default:   base_sel = base_ff;
         endcase
      end
   end

   assign prod     = acc_sel * base_sel;
   assign acc_step = prod[ValueBits-1:0] + ValueBits'(dig.val);
   assign digit_ok = dig.valid && (BaseBits'(dig.val) < base_sel);

   always_comb begin
      logic try_digit;
      logic count;
      try_digit    = 1'b0;
      count        = 1'b0;
      emit         = 1'b0;
      phase_in     = phase_ff;
      acc_in       = acc_ff;
      base_in      = base_ff;
      cons_in      = cons_ff;
      out_value_in = acc_sel;
      cnt_wide     = 32'(cnt_sel);
      out_end_in   = cnt_wide[EndBits-1:0];

      if (in_first_ff) begin
         acc_in  = '0;
         cons_in = '0;
         if (number_base_ff == RadixDetect) begin
            if (in_ch_ff == CharZero) begin
               base_in  = Radix8;
               count    = 1'b1;
               phase_in = PH_ZERO;
            end else begin
               base_in   = Radix10;
               try_digit = 1'b1;
            end
         end else begin
            base_in = number_base_ff;
            if (number_base_ff == Radix16 && in_ch_ff == CharZero) begin
               count    = 1'b1;
               phase_in = PH_HEX0;
            end else begin
               try_digit = 1'b1;
            end
         end
      end else begin
         unique case (phase_ff)
            PH_ZERO: begin
               if (is_x(in_ch_ff)) begin
                  count    = 1'b1;
                  phase_in = PH_ZERO_X;
               end else begin
                  base_in   = Radix8;
                  try_digit = 1'b1;
               end
            end
            PH_ZERO_X: begin
               if (dig.valid) begin
                  base_in   = Radix16;
                  try_digit = 1'b1;
               end else begin
                  // A bare "0x" ends as the single zero before the x.
                  emit         = 1'b1;
                  out_value_in = '0;
                  out_end_in   = EndBits'(1);
                  phase_in     = PH_IDLE;
               end
            end
            PH_HEX0: begin
               if (is_x(in_ch_ff)) begin
                  count    = 1'b1;
                  phase_in = PH_DIGITS;
               end else begin
                  try_digit = 1'b1;
               end
            end
            PH_DIGITS: try_digit = 1'b1;
            default: phase_in = phase_ff;
         endcase
      end

      if (try_digit) begin
         if (digit_ok) begin
            acc_in   = acc_step;
            count    = 1'b1;
            phase_in = PH_DIGITS;
         end else begin
            emit     = 1'b1;
            phase_in = PH_IDLE;
         end
      end

      if (count) begin
         cons_in = cnt_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         acc_ff   <= '0;
         base_ff  <= '0;
         cons_ff  <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         base_ff  <= base_in;
         cons_ff  <= cons_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         out_value_ff <= out_value_in;
         out_end_ff   <= out_end_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_end_ff, out_value_ff};

endmodule

@@ tb/unsigned_number_text_parser_tb.sv @@
// ----------------------------------------------------------------------------
// Unsigned number text parser testbench
// Streams character strings into the parser under several radix settings,
// predicts every number beat from its own model of the parse state, and
// checks each result beat field by field in order, with random idling on both
// channels and one long receiver hold-off that backs the parser up.
// ----------------------------------------------------------------------------
module unsigned_number_text_parser_tb;
   import untp_pkg::*;

   localparam int          CycleLimit    = 600000;
   localparam int          SettleCycles  = 8;
   localparam int          PhaseChars    = 70;
   localparam int          LongRunDigits = 72;
   localparam int          HoldMinChars  = 20;
   localparam logic [4:0]  NoDigit       = 5'd31;
   localparam logic [4:0]  RadixBinary   = 5'd2;
   localparam logic [4:0]  RadixUnary    = 5'd1;
   localparam logic [4:0]  RadixOver     = 5'd17;
   localparam logic [4:0]  RadixTop      = 5'd31;
   localparam logic [AddrBits-1:0] UnusedRegAddr = 3'd4;
   localparam logic [4:0]  BasePlan [10] = '{RadixDetect, Radix16, Radix10, RadixBinary,
                                             Radix8, RadixDetect, RadixTop, RadixOver,
                                             RadixUnary, RadixDetect};

   typedef struct packed {
      logic [7:0] ch;
      logic       first;
   } char_beat_type;

   typedef struct packed {
      logic [63:0] value;
      logic [15:0] end_offset;
   } number_type;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_tvalid  = 1'b0;
   logic                req_tready;
   logic [7:0]          req_tdata   = 8'h00;   // [7:0] ch
   logic                req_tuser   = 1'b0;    // [0] first
   logic                rsp_tvalid;
   logic                rsp_tready  = 1'b0;
   logic [79:0]         rsp_tdata;             // [63:0] value, [79:64] end_offset
   logic                csr_psel    = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite  = 1'b0;
   logic [AddrBits-1:0] csr_paddr   = '0;
   logic [31:0]         csr_pwdata  = '0;
   logic [31:0]         csr_prdata;
   logic                csr_pready;

   char_beat_type pending_chars[$];
   number_type    expected_numbers[$];
   char_beat_type next_beat;

   // Predicted parser state.
   logic [4:0]            base_setting = RadixDetect;
   phase_type             parse_phase  = PH_IDLE;
   logic [63:0]           acc          = '0;
   logic [4:0]            radix        = '0;
   logic [OffsetBits-1:0] consumed     = '0;

   bit idle_on       = 1'b0;
   bit start_pending = 1'b0;
   bit req_fired     = 1'b0;
   bit hold_done     = 1'b0;
   int req_gap       = 0;
   int stall_left    = 0;
   int hold_left     = 0;
   int results_seen  = 0;
   int mismatches    = 0;
   int cycle_count   = 0;

   unsigned_number_text_parser u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic [4:0] digit_value(input logic [7:0] c);
      if (c >= "0" && c <= "9") return 5'(c - "0");
      if (c >= "a" && c <= "f") return 5'(c - "a" + 10);
      if (c >= "A" && c <= "F") return 5'(c - "A" + 10);
      return NoDigit;
   endfunction

   function automatic void count_char();
      if (consumed != '1) consumed = consumed + 1'b1;
   endfunction

   function automatic void finish_number(input logic [63:0] v, input logic [15:0] off);
      expected_numbers.push_back('{value: v, end_offset: off});
      parse_phase = PH_IDLE;
   endfunction

   function automatic void accept_digit(input logic [7:0] c);
      logic [4:0] d;
      d = digit_value(c);
      if (d != NoDigit && d < radix) begin
         acc = acc * 64'(radix) + 64'(d);
         count_char();
         parse_phase = PH_DIGITS;
      end else begin
         finish_number(acc, consumed[15:0]);
      end
   endfunction

   function automatic void parse_char(input logic [7:0] c, input logic start);
      if (start) begin
         acc      = '0;
         consumed = '0;
         if (base_setting == RadixDetect) begin
            if (c == CharZero) begin
               radix = Radix8;
               count_char();
               parse_phase = PH_ZERO;
            end else begin
               radix = Radix10;
               accept_digit(c);
            end
         end else begin
            radix = base_setting;
            if (base_setting == Radix16 && c == CharZero) begin
               count_char();
               parse_phase = PH_HEX0;
            end else begin
               accept_digit(c);
            end
         end
      end else begin
         case (parse_phase)
            PH_ZERO: begin
               if ((c | CaseBit) == CharLowX) begin
                  count_char();
                  parse_phase = PH_ZERO_X;
               end else begin
                  radix = Radix8;
                  accept_digit(c);
               end
            end
            PH_ZERO_X: begin
               // Without a hex digit after the x only the leading zero counts.
               if (digit_value(c) != NoDigit) begin
                  radix = Radix16;
                  accept_digit(c);
               end else begin
                  finish_number('0, 16'd1);
               end
            end
            PH_HEX0: begin
               if ((c | CaseBit) == CharLowX) begin
                  count_char();
                  parse_phase = PH_DIGITS;
               end else begin
                  accept_digit(c);
               end
            end
            PH_DIGITS: accept_digit(c);
            default: ;
         endcase
      end
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic void push_char(input logic [7:0] c, input logic first);
      pending_chars.push_back('{ch: c, first: first});
   endfunction

   function automatic void push_in_string(input logic [7:0] c);
      push_char(c, start_pending);
      start_pending = 1'b0;
   endfunction

   function automatic void push_text(input string s);
      start_pending = 1'b1;
      for (int i = 0; i < s.len(); i++) push_in_string(s[i]);
   endfunction

   function automatic logic [7:0] random_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [7:0] x_char();
      return $urandom_range(0, 1) ? "x" : "X";
   endfunction

   // Mostly well-formed strings: optional prefix, digits of the radix with
   // random case, a random terminator and a few trailing characters.
   function automatic void push_random_string(input logic [4:0] base);
      int         kind;
      int         ndig;
      int         lim;
      int         d;
      logic [4:0] eff;
      kind = $urandom_range(0, 9);
      if ($urandom_range(0, 7) == 0) push_char(random_byte(), 1'b0);
      start_pending = 1'b1;
      if (kind == 0) begin
         push_in_string(random_byte());
         repeat ($urandom_range(0, 4)) push_char(random_byte(), 1'b0);
         return;
      end
      eff = base;
      if (base == RadixDetect) begin
         d = $urandom_range(0, 2);
         if (d == 0) begin
            push_in_string(CharZero);
            eff = Radix8;
         end else if (d == 1) begin
            push_in_string(CharZero);
            push_in_string(x_char());
            eff = Radix16;
         end else begin
            eff = Radix10;
         end
      end else if (base == Radix16 && $urandom_range(0, 1)) begin
         push_in_string(CharZero);
         push_in_string(x_char());
      end
      ndig = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 24) : $urandom_range(0, 8);
      lim  = (eff > 16) ? 16 : int'(eff);
      repeat (ndig) begin
         d = $urandom_range(0, lim - 1);
         if (d < 10) push_in_string(8'("0" + d));
         else push_in_string(8'(($urandom_range(0, 1) ? "a" : "A") + d - 10));
      end
      // Occasionally the string is left open so the next start drops it.
      if ($urandom_range(0, 9) != 0) begin
         push_in_string(random_byte());
         repeat ($urandom_range(0, 3)) push_char(random_byte(), 1'b0);
      end
   endfunction

   task automatic csr_write(input logic [AddrBits-1:0] addr, input logic [31:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (addr == RegNumberBase) base_setting = data[4:0];
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic wait_idle();
      @(posedge clock);
      while (pending_chars.size() != 0 || req_tvalid || expected_numbers.size() != 0)
         @(posedge clock);
      // A trailing character may cause no result yet still be in flight.
      repeat (SettleCycles) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- driver

   always @(negedge clock) begin
      if (!reset && (!req_tvalid || req_fired)) begin
         if (req_gap > 0) begin
            req_gap    <= req_gap - 1;
            req_tvalid <= 1'b0;
         end else if (pending_chars.size() != 0) begin
            next_beat = pending_chars.pop_front();
            req_tdata  <= next_beat.ch;
            req_tuser  <= next_beat.first;
            req_tvalid <= 1'b1;
            if (idle_on && $urandom_range(0, 5) == 0) req_gap <= $urandom_range(1, 9);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- receiver

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (!hold_done && results_seen >= 40 && pending_chars.size() > HoldMinChars) begin
         // Long hold-off while characters keep coming, to fill the parser.
         hold_done  <= 1'b1;
         hold_left  <= 80;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 8);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin
      number_type want;
      number_type got;
      if (reset) begin
         req_fired <= 1'b0;
      end else begin
         req_fired <= req_tvalid && req_tready;
         if (rsp_tvalid && rsp_tready) begin
            results_seen <= results_seen + 1;
            got.value      = rsp_tdata[63:0];
            got.end_offset = rsp_tdata[79:64];
            if (expected_numbers.size() == 0) begin
               $display("%0t unexpected result beat value %h end_offset %h",
                        $time, got.value, got.end_offset);
               mismatches++;
            end else begin
               want = expected_numbers.pop_front();
               if (got.value !== want.value) begin
                  $display("%0t value expected %h actual %h", $time, want.value, got.value);
                  mismatches++;
               end
               if (got.end_offset !== want.end_offset) begin
                  $display("%0t end_offset expected %h actual %h",
                           $time, want.end_offset, got.end_offset);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready) parse_char(req_tdata, req_tuser);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("FAILURE");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Detect mode: decimal, hex prefix, bare 0x, octal, restart mid-number.
      csr_write(RegNumberBase, 32'(RadixDetect));
      push_char("5", 1'b0);
      push_text("123");
      push_char(8'hFF, 1'b0);
      push_text("0x1F;");
      push_text("0Xg");
      push_text("017");
      push_char(8'h00, 1'b0);
      push_text("12");
      push_text("7 ");
      wait_idle();

      // A write to an address with no register must leave detect mode alone.
      csr_write(UnusedRegAddr, 32'd5);
      push_text("99 ");
      wait_idle();

      csr_write(RegNumberBase, 32'(Radix16));
      push_text("0x;");
      push_text("ffffffffffffffff ");
      wait_idle();

      csr_write(RegNumberBase, 32'(RadixUnary));
      push_text("01");
      wait_idle();

      csr_write(RegNumberBase, 32'(RadixTop));
      push_text("f!");
      wait_idle();

      // A binary string longer than 64 digits wraps the accumulator.
      csr_write(RegNumberBase, 32'(RadixBinary));
      push_text("1");
      repeat (LongRunDigits) push_char($urandom_range(0, 1) ? "1" : "0", 1'b0);
      push_char(" ", 1'b0);
      wait_idle();

      for (int i = 0; i < 10; i++) begin
         idle_on = (i % 3 != 2) && (i != 9);
         csr_write(RegNumberBase, 32'(BasePlan[i]));
         while (pending_chars.size() < PhaseChars) push_random_string(BasePlan[i]);
         wait_idle();
      end

      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
